// ===== sv/cia_pkg.sv =====
// Shared types and codes for the checked integer ALU.
`default_nettype none
package cia_pkg;

  localparam int DataW     = 64;
  localparam int MaxWidthD = 64;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_NEG = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_DIV0  = 2'd2
  } status_e;

  // Request fields that ride alongside the divider.
  typedef struct packed {
    logic             is_mul;
    logic             is_div;
    logic             q_neg;
    logic [DataW-1:0] mask;
    status_e          status;
    logic [DataW-1:0] res;
  } side_t;

  // Operands and limits handed to the multiplier.
  typedef struct packed {
    logic [DataW-1:0] ma;
    logic [DataW-1:0] mb;
    logic             negp;
    logic             sgn;
    logic [DataW-1:0] mask;
    logic [DataW-1:0] lim;
  } mul_req_t;

endpackage
`default_nettype wire

// ===== sv/cia_prep.sv =====
// Front stage: width decode, operand extension, add/sub/negate and error checks.
`default_nettype none
module cia_prep import cia_pkg::*; #(
  parameter int MaxWidth = MaxWidthD
) (
  input  wire logic                clk_i,
  input  wire logic [2:0]          cmd_i,
  input  wire logic                is_signed_i,
  input  wire logic [1:0]          width_code_i,
  input  wire logic [DataW-1:0]    left_operand_i,
  input  wire logic [DataW-1:0]    right_operand_i,
  output side_t                    side_o,
  output mul_req_t                 mul_req_o,
  output logic [MaxWidth-1:0]      dividend_o,
  output logic [MaxWidth-1:0]      divisor_o
);

  side_t            side_d, side_q;
  mul_req_t         mul_d, mul_q;
  logic [MaxWidth-1:0] dvd_d, dvd_q, dvs_d, dvs_q;

  logic [6:0]       full_w, w;
  logic [DataW-1:0] mask, lim, a, b, sa, sb, smin, ma, mb;
  logic [DataW:0]   sum, dif;
  logic             sgn, sum_fit, dif_fit;

  function automatic logic fits_signed(input logic [DataW:0] x,
                                       input logic [DataW-1:0] m,
                                       input logic [DataW-1:0] l);
    logic [DataW-1:0] lo, sx;
    lo = x[DataW-1:0] & m;
    sx = lo | (((lo & l) != '0) ? ~m : '0);
    return x == {sx[DataW-1], sx};
  endfunction

  always_comb begin
    case (width_code_i)
      2'd0:    full_w = 7'd8;
      2'd1:    full_w = 7'd16;
      2'd2:    full_w = 7'd32;
      default: full_w = 7'd64;
    endcase
    w    = (full_w > 7'(MaxWidth)) ? 7'(MaxWidth) : full_w;
    mask = {DataW{1'b1}} >> (7'd64 - w);
    lim  = DataW'(1) << (w - 7'd1);
    sgn  = is_signed_i;
    a    = left_operand_i & mask;
    b    = right_operand_i & mask;
    sa   = a | (((a & lim) != '0) ? ~mask : '0);
    sb   = b | (((b & lim) != '0) ? ~mask : '0);
    smin = ~mask | lim;
    ma   = (sgn && sa[DataW-1]) ? -sa : (sgn ? sa : a);
    mb   = (sgn && sb[DataW-1]) ? -sb : (sgn ? sb : b);
    sum  = sgn ? ({sa[DataW-1], sa} + {sb[DataW-1], sb}) : ({1'b0, a} + {1'b0, b});
    dif  = sgn ? ({sa[DataW-1], sa} - {sb[DataW-1], sb}) : ({1'b0, a} - {1'b0, b});
    sum_fit = sgn ? fits_signed(sum, mask, lim) : (sum <= {1'b0, mask});
    dif_fit = sgn ? fits_signed(dif, mask, lim) : (b <= a);

    side_d.is_mul = 1'b0;
    side_d.is_div = 1'b0;
    side_d.q_neg  = sgn & (sa[DataW-1] ^ sb[DataW-1]);
    side_d.mask   = mask;
    side_d.status = ST_OK;
    side_d.res    = '0;
    case (cmd_e'(cmd_i))
      CMD_ADD: begin
        if (sum_fit) side_d.res = sum[DataW-1:0] & mask;
        else         side_d.status = ST_RANGE;
      end
      CMD_SUB: begin
        if (dif_fit) side_d.res = dif[DataW-1:0] & mask;
        else         side_d.status = ST_RANGE;
      end
      CMD_MUL: side_d.is_mul = 1'b1;
      CMD_DIV: begin
        side_d.is_div = 1'b1;
        if (sgn && sa == smin && sb == {DataW{1'b1}}) side_d.status = ST_RANGE;
        else if (b == '0)                             side_d.status = ST_DIV0;
      end
      CMD_NEG: begin
        if (sgn) begin
          if (sb == smin) side_d.status = ST_RANGE;
          else            side_d.res = (-sb) & mask;
        end else if (b != '0) begin
          side_d.status = ST_RANGE;
        end
      end
      default: side_d.status = ST_RANGE;
    endcase

    mul_d.ma   = ma;
    mul_d.mb   = mb;
    mul_d.negp = sgn & (sa[DataW-1] ^ sb[DataW-1]);
    mul_d.sgn  = sgn;
    mul_d.mask = mask;
    mul_d.lim  = lim;
    dvd_d      = ma[MaxWidth-1:0];
    dvs_d      = mb[MaxWidth-1:0];
  end

  always_ff @(posedge clk_i) begin
    side_q <= side_d;
    mul_q  <= mul_d;
    dvd_q  <= dvd_d;
    dvs_q  <= dvs_d;
  end

  assign side_o     = side_q;
  assign mul_req_o  = mul_q;
  assign dividend_o = dvd_q;
  assign divisor_o  = dvs_q;

endmodule
`default_nettype wire

// ===== sv/cia_mul.sv =====
// Three-stage 64x64 multiplier with range check on the product.
`default_nettype none
module cia_mul import cia_pkg::*; (
  input  wire logic             clk_i,
  input  mul_req_t              req_i,
  output logic [DataW-1:0]      res_o,
  output logic                  range_o
);

  logic [DataW-1:0]   p0_q, p1_q, p2_q, p3_q;
  logic [2*DataW-1:0] prod_d, prod_q;
  mul_req_t           r1_q, r2_q;
  logic [DataW-1:0]   res_d, res_q, hi, lo, bound;
  logic               range_d, range_q;

  always_comb begin
    prod_d = {p3_q, p0_q} + ({64'd0, p1_q} << 32) + ({64'd0, p2_q} << 32);
    hi     = prod_q[2*DataW-1:DataW];
    lo     = prod_q[DataW-1:0];
    if (r2_q.sgn) bound = r2_q.negp ? r2_q.lim : r2_q.lim - DataW'(1);
    else          bound = r2_q.mask;
    range_d = (hi != '0) || (lo > bound);
    if (range_d) res_d = '0;
    else         res_d = (r2_q.negp ? -lo : lo) & r2_q.mask;
  end

  always_ff @(posedge clk_i) begin
    p0_q    <= DataW'(req_i.ma[31:0])  * DataW'(req_i.mb[31:0]);
    p1_q    <= DataW'(req_i.ma[31:0])  * DataW'(req_i.mb[63:32]);
    p2_q    <= DataW'(req_i.ma[63:32]) * DataW'(req_i.mb[31:0]);
    p3_q    <= DataW'(req_i.ma[63:32]) * DataW'(req_i.mb[63:32]);
    r1_q    <= req_i;
    prod_q  <= prod_d;
    r2_q    <= r1_q;
    res_q   <= res_d;
    range_q <= range_d;
  end

  assign res_o   = res_q;
  assign range_o = range_q;

endmodule
`default_nettype wire

// ===== sv/cia_divider.sv =====
// Restoring divider, one quotient bit per pipeline stage.
`default_nettype none
module cia_divider #(
  parameter int Width = 64
) (
  input  wire logic             clk_i,
  input  wire logic [Width-1:0] dividend_i,
  input  wire logic [Width-1:0] divisor_i,
  output logic [Width-1:0]      quotient_o
);

  logic [Width-1:0] rem_q [Width];
  logic [Width-1:0] quo_q [Width];
  logic [Width-1:0] dvs_q [Width];

  for (genvar k = 0; k < Width; k++) begin : g_stage
    logic [Width-1:0] rem_in, quo_in, dvs_in;
    logic [Width:0]   trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = dividend_i;
      assign dvs_in = divisor_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign dvs_in = dvs_q[k-1];
    end

    assign trial = {rem_in, quo_in[Width-1]};
    assign ge    = trial >= {1'b0, dvs_in};

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? Width'(trial - {1'b0, dvs_in}) : trial[Width-1:0];
      quo_q[k] <= {quo_in[Width-2:0], ge};
      dvs_q[k] <= dvs_in;
    end
  end

  assign quotient_o = quo_q[Width-1];

endmodule
`default_nettype wire

// ===== sv/checked_integer_alu.sv =====
// Checked integer ALU: add, subtract, multiply, divide and negate with range checks.
// Accepts one request per clock; busy stays low. Every request returns one result,
// in order, flagged by result_valid_o for one cycle. The divider, which resolves one
// quotient bit per stage, sets the depth of the pipeline; all other operations are
// delayed to match. The receiver cannot stall.
`default_nettype none
module checked_integer_alu import cia_pkg::*; #(
  parameter int MAX_WIDTH = MaxWidthD
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [2:0]       cmd_i,
  input  wire logic             is_signed_i,
  input  wire logic [1:0]       width_code_i,
  input  wire logic [DataW-1:0] left_operand_i,
  input  wire logic [DataW-1:0] right_operand_i,
  output logic                  result_valid_o,
  output logic [DataW-1:0]      result_bits_o,
  output logic [1:0]            status_o
);

  localparam int Lat = MAX_WIDTH + 2;

  side_t               side, side_line_q [MAX_WIDTH];
  mul_req_t            mul_req;
  logic [MAX_WIDTH-1:0] dvd, dvs, quo;
  logic [DataW-1:0]    mul_res, mres_line_q [MAX_WIDTH-3];
  logic                mul_rng, mrng_line_q [MAX_WIDTH-3];
  logic                prep_vld_q;
  logic [MAX_WIDTH-1:0] vld_line_q;
  logic                out_vld_q;
  logic [DataW-1:0]    res_d, res_q, q64;
  status_e             st_d, st_q;
  side_t               sd;

  assign busy = 1'b0;

  cia_prep #(.MaxWidth(MAX_WIDTH)) u_prep (
    .clk_i, .cmd_i, .is_signed_i, .width_code_i, .left_operand_i, .right_operand_i,
    .side_o(side), .mul_req_o(mul_req), .dividend_o(dvd), .divisor_o(dvs)
  );

  cia_mul u_mul (.clk_i, .req_i(mul_req), .res_o(mul_res), .range_o(mul_rng));

  cia_divider #(.Width(MAX_WIDTH)) u_div (
    .clk_i, .dividend_i(dvd), .divisor_i(dvs), .quotient_o(quo)
  );

  // align request fields and product with the divider output
  always_ff @(posedge clk_i) begin
    side_line_q[0] <= side;
    for (int k = 1; k < MAX_WIDTH; k++) side_line_q[k] <= side_line_q[k-1];
    mres_line_q[0] <= mul_res;
    mrng_line_q[0] <= mul_rng;
    for (int k = 1; k < MAX_WIDTH - 3; k++) begin
      mres_line_q[k] <= mres_line_q[k-1];
      mrng_line_q[k] <= mrng_line_q[k-1];
    end
    res_q <= res_d;
    st_q  <= st_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_vld_q <= 1'b0;
      vld_line_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      prep_vld_q <= start && !busy;
      vld_line_q <= {vld_line_q[MAX_WIDTH-2:0], prep_vld_q};
      out_vld_q  <= vld_line_q[MAX_WIDTH-1];
    end
  end

  always_comb begin
    sd  = side_line_q[MAX_WIDTH-1];
    q64 = DataW'(quo);
    if (sd.is_mul) begin
      st_d  = mrng_line_q[MAX_WIDTH-4] ? ST_RANGE : ST_OK;
      res_d = mres_line_q[MAX_WIDTH-4];
    end else if (sd.is_div) begin
      st_d  = sd.status;
      res_d = (sd.status == ST_OK) ? ((sd.q_neg ? -q64 : q64) & sd.mask) : '0;
    end else begin
      st_d  = sd.status;
      res_d = sd.res;
    end
  end

  assign result_valid_o = out_vld_q;
  assign result_bits_o  = res_q;
  assign status_o       = st_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> ##(Lat-1) result_valid_o)
    else $error("result missing after fixed latency");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o != ST_OK |-> result_bits_o == '0)
    else $error("nonzero result with error status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(vld_line_q[MAX_WIDTH-1]))
    else $error("result without matching request");

endmodule
`default_nettype wire

// ===== tb/tb_checked_integer_alu.sv =====
// Self-checking testbench for the checked integer ALU.
`default_nettype none
module tb_checked_integer_alu;
  import cia_pkg::*;

  localparam int NumRandom = 1100;
  localparam int Latency   = 66;

  typedef struct {
    logic [DataW-1:0] bits;
    logic [1:0]       status;
  } alu_result_t;

  typedef struct {
    logic [2:0]       cmd;
    logic             sgn;
    logic [1:0]       wcode;
    logic [DataW-1:0] lhs;
    logic [DataW-1:0] rhs;
    logic             typed;
    logic [DataW-1:0] exp_bits;
    logic [1:0]       exp_status;
  } stim_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [2:0]       cmd_i;
  logic             is_signed_i;
  logic [1:0]       width_code_i;
  logic [DataW-1:0] left_operand_i;
  logic [DataW-1:0] right_operand_i;
  logic             result_valid_o;
  logic [DataW-1:0] result_bits_o;
  logic [1:0]       status_o;

  alu_result_t pending_results[$];
  int          mismatches;
  int          idle_pct;
  stim_row_t   directed[$];

  checked_integer_alu dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .cmd_i(cmd_i), .is_signed_i(is_signed_i), .width_code_i(width_code_i),
    .left_operand_i(left_operand_i), .right_operand_i(right_operand_i),
    .result_valid_o(result_valid_o), .result_bits_o(result_bits_o),
    .status_o(status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  // Exact arithmetic on 130-bit signed values, then fit to width.
  function automatic alu_result_t predict_alu(logic [2:0] cmd, logic sgn, logic [1:0] wcode,
                                              logic [DataW-1:0] lhs, logic [DataW-1:0] rhs);
    alu_result_t      r;
    int               w;
    logic [DataW-1:0] m;
    logic signed [129:0] a, b, x, lo, hi;
    logic             ok;
    w = 8 << wcode;
    m = (w == 64) ? '1 : ((64'd1 << w) - 1);
    a = {66'd0, lhs & m};
    b = {66'd0, rhs & m};
    if (sgn) begin
      if (a[w-1]) a = a - (130'sd1 <<< w);
      if (b[w-1]) b = b - (130'sd1 <<< w);
      lo = -(130'sd1 <<< (w - 1));
      hi = (130'sd1 <<< (w - 1)) - 1;
    end else begin
      lo = 0;
      hi = {66'd0, m};
    end
    r.status = ST_OK;
    x = 0;
    case (cmd)
      CMD_ADD: x = a + b;
      CMD_SUB: x = a - b;
      CMD_MUL: x = a * b;
      CMD_DIV: begin
        if (b == 0 && !(sgn && a == lo && b == -1)) r.status = ST_DIV0;
        else x = a / b;
      end
      CMD_NEG: x = -b;
      default: r.status = ST_RANGE;
    endcase
    ok = (x >= lo) && (x <= hi);
    if (r.status == ST_OK && !ok) r.status = ST_RANGE;
    r.bits = (r.status == ST_OK) ? (x[63:0] & m) : '0;
    return r;
  endfunction

  function automatic logic [DataW-1:0] rand_operand();
    logic [DataW-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      2: v = v >> $urandom_range(0, 63);
      3: v = 64'd1 << $urandom_range(0, 63);
      4: v = {v[63:8], 8'hff} ^ (64'd1 << $urandom_range(0, 63));
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_request(stim_row_t row);
    alu_result_t e;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start           <= 1'b1;
    cmd_i           <= row.cmd;
    is_signed_i     <= row.sgn;
    width_code_i    <= row.wcode;
    left_operand_i  <= row.lhs;
    right_operand_i <= row.rhs;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (row.typed) begin
      e.bits   = row.exp_bits;
      e.status = row.exp_status;
    end else begin
      e = predict_alu(row.cmd, row.sgn, row.wcode, row.lhs, row.rhs);
    end
    pending_results.push_back(e);
  endtask

  function automatic stim_row_t mk(logic [2:0] c, logic s, logic [1:0] wc, logic [63:0] l,
                                   logic [63:0] r, logic t, logic [63:0] eb, logic [1:0] es);
    stim_row_t x;
    x = '{c, s, wc, l, r, t, eb, es};
    return x;
  endfunction

  // Compare each strobed result with the oldest expectation.
  always @(posedge clk_i) begin
    alu_result_t e;
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h/%0d", result_bits_o, status_o);
      end else begin
        e = pending_results.pop_front();
        if (result_bits_o !== e.bits || status_o !== e.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h/%0d got %h/%0d", e.bits, e.status,
                     result_bits_o, status_o);
        end
      end
    end
  end

  initial begin
    stim_row_t row;
    int        guard;
    mismatches = 0;
    idle_pct = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    cmd_i = CMD_ADD;
    is_signed_i = 1'b0;
    width_code_i = 2'd0;
    left_operand_i = '0;
    right_operand_i = '0;
    // Extremes and error cases; typed rows where obvious.
    directed.push_back(mk(CMD_ADD, 0, 0, 64'hff, 64'h01, 1, 0, ST_RANGE));
    directed.push_back(mk(CMD_ADD, 0, 3, '1, 64'h1, 1, 0, ST_RANGE));
    directed.push_back(mk(CMD_ADD, 1, 0, 64'h7f, 64'h01, 1, 0, ST_RANGE));
    directed.push_back(mk(CMD_ADD, 0, 0, 64'hffff_ff01, 64'h02, 1, 64'h03, ST_OK));
    directed.push_back(mk(CMD_SUB, 0, 1, 64'h1, 64'h2, 1, 0, ST_RANGE));
    directed.push_back(mk(CMD_SUB, 1, 3, 64'h8000_0000_0000_0000, 64'h1, 1, 0, ST_RANGE));
    directed.push_back(mk(CMD_SUB, 1, 2, 64'h5, 64'h7, 0, 0, 0));
    directed.push_back(mk(CMD_MUL, 0, 2, '1, '1, 1, 0, ST_RANGE));
    directed.push_back(mk(CMD_MUL, 1, 0, 64'hf0, 64'h08, 0, 0, 0));
    directed.push_back(mk(CMD_MUL, 1, 3, 64'h8000_0000_0000_0000, 64'h1, 0, 0, 0));
    directed.push_back(mk(CMD_MUL, 1, 3, 64'h8000_0000_0000_0000, '1, 1, 0, ST_RANGE));
    directed.push_back(mk(CMD_DIV, 1, 0, 64'h80, 64'hff, 1, 0, ST_RANGE));
    directed.push_back(mk(CMD_DIV, 1, 3, 64'h8000_0000_0000_0000, '1, 1, 0, ST_RANGE));
    directed.push_back(mk(CMD_DIV, 0, 1, 64'h1234, 64'h0, 1, 0, ST_DIV0));
    directed.push_back(mk(CMD_DIV, 1, 2, 64'h5, 64'hffff_0000_0000_0000, 1, 0, ST_DIV0));
    directed.push_back(mk(CMD_DIV, 1, 0, 64'hf9, 64'h02, 0, 0, 0));
    directed.push_back(mk(CMD_DIV, 0, 3, '1, 64'h3, 0, 0, 0));
    directed.push_back(mk(CMD_NEG, 1, 1, 64'h0, 64'h8000, 1, 0, ST_RANGE));
    directed.push_back(mk(CMD_NEG, 0, 2, '1, 64'h0, 1, 0, ST_OK));
    directed.push_back(mk(CMD_NEG, 0, 0, 64'h0, 64'h1, 1, 0, ST_RANGE));
    directed.push_back(mk(CMD_NEG, 1, 3, 64'h0, 64'h1, 1, '1, ST_OK));
    directed.push_back(mk(3'd5, 0, 0, 64'h1, 64'h1, 1, 0, ST_RANGE));
    directed.push_back(mk(3'd7, 1, 3, '1, '1, 1, 0, ST_RANGE));
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send_request(directed[i]);
    for (int n = 0; n < NumRandom; n++) begin
      idle_pct = (n < NumRandom / 3) ? 6 : (n < 2 * NumRandom / 3) ? 64 : 0;
      row.cmd   = ($urandom_range(0, 31) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4));
      row.sgn   = 1'($urandom);
      row.wcode = 2'($urandom);
      row.lhs   = rand_operand();
      row.rhs   = rand_operand();
      row.typed = 1'b0;
      send_request(row);
    end
    start <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 10 * Latency) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (Latency) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
sv/cia_pkg.sv
sv/cia_prep.sv
sv/cia_mul.sv
sv/cia_divider.sv
sv/checked_integer_alu.sv
tb/tb_checked_integer_alu.sv
